// ----- hdl/ertt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ertt_pkg
// Shared types and constants of the echo request tracking table.
// ----------------------------------------------------------------------------
package ertt_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    localparam logic [2:0] OP_TRACK = 3'd0;
    localparam logic [2:0] OP_REPLY = 3'd1;
    localparam logic [2:0] OP_GET   = 3'd2;
    localparam logic [2:0] OP_NEXT  = 3'd3;
    localparam logic [2:0] OP_HAS   = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_PENDING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // one table row as stored in the entry RAM
    typedef struct packed {
        logic        resolved;
        logic [15:0] id;
        logic [15:0] seq;
        logic [31:0] addr;
        logic [31:0] sent;
        logic [31:0] rtt;
        logic [7:0]  ttl;
        logic [15:0] plen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

// ----- hdl/ertt_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ertt channel interfaces
// Request, response and timeout configuration channels, valid/ready.
// ----------------------------------------------------------------------------
interface ertt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [31:0] peer_addr;
    logic [31:0] now_ms;
    logic [7:0]  rx_ttl;
    logic [15:0] payload_len;
    modport source (output valid, opcode, echo_id, echo_seq, peer_addr, now_ms,
                    rx_ttl, payload_len, input ready);
    modport sink   (input valid, opcode, echo_id, echo_seq, peer_addr, now_ms,
                    rx_ttl, payload_len, output ready);
endinterface

interface ertt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] result_seq;
    logic [31:0] rtt_ms;
    logic [7:0]  out_ttl;
    logic [15:0] out_payload_len;
    logic [31:0] reply_addr;
    modport source (output valid, status, result_seq, rtt_ms, out_ttl,
                    out_payload_len, reply_addr, input ready);
    modport sink   (input valid, status, result_seq, rtt_ms, out_ttl,
                    out_payload_len, reply_addr, output ready);
endinterface

interface ertt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] timeout_ms;
    modport source (output valid, timeout_ms, input ready);
    modport sink   (input valid, timeout_ms, output ready);
endinterface
`default_nettype wire

// ----- hdl/ertt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ertt_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module ertt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/echo_request_tracking_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// echo_request_tracking_table
// Flow: a request is captured in idle; opcodes 0..4 then sweep the table, one
//   RAM read per entry for expiry and match, other opcodes skip the sweep.
// Requests: one at a time; the response register frees the input while the
//   result waits.
// Reset (i_rst_n low, synchronous): table empty, timeout back to 10000 ms.
// ----------------------------------------------------------------------------
module echo_request_tracking_table import ertt_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ertt_req_if.sink   i_req,
    ertt_rsp_if.source o_rsp,
    ertt_cfg_if.sink   i_cfg
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FINISH} t_state;

    t_state r_state;

    // captured request
    logic [2:0]  r_op;
    logic [15:0] r_id, r_seq, r_plen;
    logic [31:0] r_addr, r_now;
    logic [7:0]  r_ttl;

    logic [31:0] r_timeout;

    // valid bits and insertion ranks (0 = oldest, dense over valid entries)
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_rank [ENTRIES];
    logic [CW-1:0]      r_count;

    // sweep pipeline: read issue, then check in the next cycle
    logic [CW-1:0] r_rd_idx;
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;

    // oldest matching entry so far
    logic          r_hit;
    logic [IW-1:0] r_best;
    t_entry        r_best_e;

    // response register
    logic        r_ov;
    logic [1:0]  r_status;
    logic [15:0] r_rseq, r_rplen;
    logic [31:0] r_rtt, r_raddr;
    logic [7:0]  r_rttl;

    t_entry        rd_e;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [IW-1:0] free_idx;
    logic          fin_go;
    logic          rd_issue;
    logic          is_hit;
    logic [31:0]   age;

    ertt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (rd_e)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid           = r_ov;
    assign o_rsp.status          = r_status;
    assign o_rsp.result_seq      = r_rseq;
    assign o_rsp.rtt_ms          = r_rtt;
    assign o_rsp.out_ttl         = r_rttl;
    assign o_rsp.out_payload_len = r_rplen;
    assign o_rsp.reply_addr      = r_raddr;

    assign rd_issue = (r_state == S_SWEEP) && (r_rd_idx < CW'(ENTRIES));
    assign fin_go   = (r_state == S_FINISH) && (!r_ov || o_rsp.ready);
    assign age      = r_now - rd_e.sent;

    // lowest free slot for a new request
    always_comb begin
        logic found;
        found    = 1'b0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && !r_valid[i]) begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // match test of the entry under check, by opcode
    always_comb begin
        is_hit = 1'b0;
        unique case (r_op) inside
            OP_REPLY:        is_hit = (rd_e.id == r_id) && (rd_e.seq == r_seq)
                                      && (rd_e.addr == r_addr);
            OP_GET:          is_hit = (rd_e.id == r_id) && (rd_e.seq == r_seq);
            OP_NEXT, OP_HAS: is_hit = (rd_e.id == r_id) && rd_e.resolved;
            default:         is_hit = 1'b0;
        endcase
    end

    // write back: new row on track, updated row on reply
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best;
        ram_wdata = r_best_e;
        if (r_op == OP_TRACK) begin
            ram_we    = fin_go && (r_count != CW'(ENTRIES));
            ram_waddr = free_idx;
            ram_wdata = '{resolved: 1'b0, id: r_id, seq: r_seq, addr: r_addr,
                          sent: r_now, rtt: '0, ttl: '0, plen: '0};
        end else if (r_op == OP_REPLY) begin
            ram_we             = fin_go && r_hit;
            ram_wdata.resolved = 1'b1;
            ram_wdata.rtt      = r_now - r_best_e.sent;
            ram_wdata.ttl      = r_ttl;
            ram_wdata.plen     = r_plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= TIMEOUT_RESET;
            r_valid   <= '0;
            r_count   <= '0;
            r_chk     <= 1'b0;
            r_hit     <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.timeout_ms;
            end
            if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= i_req.opcode;
                        r_id     <= i_req.echo_id;
                        r_seq    <= i_req.echo_seq;
                        r_addr   <= i_req.peer_addr;
                        r_now    <= i_req.now_ms;
                        r_ttl    <= i_req.rx_ttl;
                        r_plen   <= i_req.payload_len;
                        r_rd_idx <= '0;
                        r_chk    <= 1'b0;
                        r_hit    <= 1'b0;
                        // undefined opcodes skip the sweep
                        r_state  <= (i_req.opcode > OP_HAS) ? S_FINISH : S_SWEEP;
                    end
                end

                S_SWEEP: begin
                    r_chk     <= rd_issue;
                    r_chk_idx <= r_rd_idx[IW-1:0];
                    if (rd_issue) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end else if (!r_chk) begin
                        r_state <= S_FINISH;
                    end
                    if (r_chk && r_valid[r_chk_idx]) begin
                        if (age > r_timeout) begin
                            // expired: drop and close the rank gap
                            r_valid[r_chk_idx] <= 1'b0;
                            r_count            <= r_count - 1'b1;
                            for (int j = 0; j < ENTRIES; j++) begin
                                if (r_valid[j] && r_rank[j] > r_rank[r_chk_idx]) begin
                                    r_rank[j] <= r_rank[j] - 1'b1;
                                end
                            end
                        end else if (is_hit &&
                                     (!r_hit || r_rank[r_chk_idx] < r_rank[r_best])) begin
                            r_hit    <= 1'b1;
                            r_best   <= r_chk_idx;
                            r_best_e <= rd_e;
                        end
                    end
                end

                S_FINISH: begin
                    if (fin_go) begin
                        r_state  <= S_IDLE;
                        r_ov     <= 1'b1;
                        r_status <= ST_MISS;
                        r_rseq   <= '0;
                        r_rtt    <= '0;
                        r_rttl   <= '0;
                        r_rplen  <= '0;
                        r_raddr  <= '0;
                        if ((r_op == OP_TRACK) && (r_count == CW'(ENTRIES))) begin
                            r_status <= ST_FULL;
                        end else if (r_op == OP_TRACK) begin
                            r_status          <= ST_DONE;
                            r_valid[free_idx] <= 1'b1;
                            r_rank[free_idx]  <= r_count[IW-1:0];
                            r_count           <= r_count + 1'b1;
                        end else if (r_hit && ((r_op == OP_REPLY) || (r_op == OP_HAS))) begin
                            r_status <= ST_DONE;
                        end else if (r_hit && (r_op == OP_GET) && !r_best_e.resolved) begin
                            r_status <= ST_PENDING;
                        end else if (r_hit && ((r_op == OP_GET) || (r_op == OP_NEXT))) begin
                            // hand out the row and remove it
                            r_status        <= ST_DONE;
                            r_rseq          <= r_best_e.seq;
                            r_rtt           <= r_best_e.rtt;
                            r_rttl          <= r_best_e.ttl;
                            r_rplen         <= r_best_e.plen;
                            r_raddr         <= r_best_e.addr;
                            r_valid[r_best] <= 1'b0;
                            r_count         <= r_count - 1'b1;
                            for (int j = 0; j < ENTRIES; j++) begin
                                if (r_valid[j] && r_rank[j] > r_rank[r_best]) begin
                                    r_rank[j] <= r_rank[j] - 1'b1;
                                end
                            end
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
